[hdl/hpt_pkg.sv]
// ----------------------------------------------------------------------------
// hpt_pkg: shared definitions for the homogeneous point transform
// Field widths, item kind codes, parameter defaults and the control word
// that travels down the chain of column cells.
// ----------------------------------------------------------------------------
package hpt_pkg;

	// Widths of the fields on the request and result channels.
	localparam int FIELD_BITS = 32;
	localparam int IDX_BITS   = 2;

	// Number of point components carried by a request.
	localparam int POINT_COMPS = 4;

	// Defaults for the top-level parameters.
	localparam int DIM_DEF       = 4;
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	// Request kinds.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_XFORM = 1'b1;

	// Control word that moves with every request through the cells.
	typedef struct packed {
		logic                valid;
		logic                kind;
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
	} cell_ctl_t;

endpackage

[hdl/hpt_in_if.sv]
// ----------------------------------------------------------------------------
// hpt_in_if: request channel of the homogeneous point transform
// Carries a matrix entry load or a point to transform, with valid/ready.
// ----------------------------------------------------------------------------
interface hpt_in_if;
	import hpt_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [IDX_BITS-1:0]          row;
	logic [IDX_BITS-1:0]          col;
	logic signed [FIELD_BITS-1:0] entry_value;
	logic signed [FIELD_BITS-1:0] in_x;
	logic signed [FIELD_BITS-1:0] in_y;
	logic signed [FIELD_BITS-1:0] in_z;
	logic signed [FIELD_BITS-1:0] in_w;

	modport source (
		output valid, kind, row, col, entry_value, in_x, in_y, in_z, in_w,
		input  ready
	);

	modport sink (
		input  valid, kind, row, col, entry_value, in_x, in_y, in_z, in_w,
		output ready
	);

endinterface

[hdl/hpt_out_if.sv]
// ----------------------------------------------------------------------------
// hpt_out_if: result channel of the homogeneous point transform
// Carries the transformed point and the saturation flag, with valid/ready.
// ----------------------------------------------------------------------------
interface hpt_out_if;
	import hpt_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [FIELD_BITS-1:0] out_x;
	logic signed [FIELD_BITS-1:0] out_y;
	logic signed [FIELD_BITS-1:0] out_z;
	logic signed [FIELD_BITS-1:0] out_w;
	logic                         saturated;

	modport source (
		output valid, out_x, out_y, out_z, out_w, saturated,
		input  ready
	);

	modport sink (
		input  valid, out_x, out_y, out_z, out_w, saturated,
		output ready
	);

endinterface

[hdl/hpt_cell.sv]
// ----------------------------------------------------------------------------
// hpt_cell: one column cell of the transform chain
// Holds one matrix column, multiplies it by its point component and adds
// the products onto the running row sums handed on by the previous cell.
// ----------------------------------------------------------------------------
module hpt_cell #(
	parameter int DIM       = 4,
	parameter int WORD_BITS = 32,
	parameter int ACC_BITS  = 67,
	parameter int COL       = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  hpt_pkg::cell_ctl_t             ctl_i,
	input  logic signed [WORD_BITS-1:0]    value_i,
	input  logic signed [WORD_BITS-1:0]    point_i [DIM],
	input  logic signed [ACC_BITS-1:0]     acc_i   [DIM],
	output hpt_pkg::cell_ctl_t             ctl_o,
	output logic signed [WORD_BITS-1:0]    value_o,
	output logic signed [WORD_BITS-1:0]    point_o [DIM],
	output logic signed [ACC_BITS-1:0]     acc_o   [DIM]
);
	import hpt_pkg::*;

	localparam int PROD_BITS = 2 * WORD_BITS;

	logic signed [WORD_BITS-1:0] entries_q [DIM];

	cell_ctl_t                   ctl_s1;
	logic signed [WORD_BITS-1:0] value_s1;
	logic signed [WORD_BITS-1:0] point_s1 [DIM];
	logic signed [ACC_BITS-1:0]  acc_s1   [DIM];
	logic signed [PROD_BITS-1:0] prod_s1  [DIM];

	cell_ctl_t                   ctl_s2;
	logic signed [WORD_BITS-1:0] value_s2;
	logic signed [WORD_BITS-1:0] point_s2 [DIM];
	logic signed [ACC_BITS-1:0]  acc_s2   [DIM];

	logic load_here;

	// A load takes effect as it passes this cell, so it stays ordered with
	// the transforms around it.
	assign load_here = adv && ctl_i.valid && (ctl_i.kind == KIND_LOAD)
		&& (int'(ctl_i.col) == COL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < DIM; r++) begin
				entries_q[r] <= '0;
			end
		end else if (load_here) begin
			for (int r = 0; r < DIM; r++) begin
				if (int'(ctl_i.row) == r) begin
					entries_q[r] <= value_i;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s1 <= value_i;
			value_s2 <= value_s1;
			for (int r = 0; r < DIM; r++) begin
				point_s1[r] <= point_i[r];
				acc_s1[r]   <= acc_i[r];
				prod_s1[r]  <= entries_q[r] * point_i[COL];
				point_s2[r] <= point_s1[r];
				acc_s2[r]   <= acc_s1[r] + ACC_BITS'(prod_s1[r]);
			end
		end
	end

	assign ctl_o   = ctl_s2;
	assign value_o = value_s2;
	assign point_o = point_s2;
	assign acc_o   = acc_s2;

endmodule

[hdl/hpt_sat.sv]
// ----------------------------------------------------------------------------
// hpt_sat: scaling, saturation and output register
// Shifts the finished row sums down by the fraction width, clips them to
// the word range and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module hpt_sat #(
	parameter int DIM       = 4,
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	parameter int ACC_BITS  = 67
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hpt_pkg::cell_ctl_t         ctl_i,
	input  logic signed [ACC_BITS-1:0] acc_i [DIM],
	output logic                       adv,
	hpt_out_if.source                  result
);
	import hpt_pkg::*;

	localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	logic signed [ACC_BITS-1:0]   shifted [DIM];
	logic signed [WORD_BITS-1:0]  clipped [DIM];
	logic        [DIM-1:0]        clip;
	logic signed [FIELD_BITS-1:0] comp    [POINT_COMPS];

	logic                         valid_q;
	logic signed [FIELD_BITS-1:0] x_q, y_q, z_q, w_q;
	logic                         sat_q;

	always_comb begin
		for (int r = 0; r < DIM; r++) begin
			shifted[r] = acc_i[r] >>> FRAC_BITS;
			// The value fits when every bit above the word's sign bit
			// repeats that sign bit.
			if ((&shifted[r][ACC_BITS-1:WORD_BITS-1])
					|| !(|shifted[r][ACC_BITS-1:WORD_BITS-1])) begin
				clipped[r] = shifted[r][WORD_BITS-1:0];
				clip[r]    = 1'b0;
			end else begin
				clipped[r] = shifted[r][ACC_BITS-1] ? WMIN : WMAX;
				clip[r]    = 1'b1;
			end
		end
		for (int r = 0; r < POINT_COMPS; r++) begin
			comp[r] = '0;
			if (r < DIM) begin
				comp[r] = FIELD_BITS'(clipped[r]);
			end
		end
	end

	assign adv = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= ctl_i.valid && (ctl_i.kind == KIND_XFORM);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_q   <= comp[0];
			y_q   <= comp[1];
			z_q   <= comp[2];
			w_q   <= comp[3];
			sat_q <= |clip;
		end
	end

	assign result.valid     = valid_q;
	assign result.out_x     = x_q;
	assign result.out_y     = y_q;
	assign result.out_z     = z_q;
	assign result.out_w     = w_q;
	assign result.saturated = sat_q;

endmodule

[hdl/homogeneous_point_transform.sv]
// Each request passes the multiply and accumulate registers of every column cell, then the output register.
// Throughput: one request per cycle; each column cell spends a multiply stage and an
// accumulate stage, and the whole chain stalls only while a result waits to be taken.
// Loads travel the chain too and give no result.
// Reset (arst_n low) clears every matrix entry to zero and empties the pipeline.
// ----------------------------------------------------------------------------
// homogeneous_point_transform: 4x4 fixed-point matrix times homogeneous point
// A chain of column cells holds the matrix; each request flows through it,
// loading an entry or accumulating the exact row dot products of a point.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
	parameter int DIM       = hpt_pkg::DIM_DEF,
	parameter int WORD_BITS = hpt_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	hpt_in_if.sink    item,
	hpt_out_if.source result
);
	import hpt_pkg::*;

	// Room for the exact sum of DIM full-width products.
	localparam int ACC_BITS = 2 * WORD_BITS + $clog2(DIM) + 1;

	// The chain moves as one: every stage advances whenever the output
	// register is free or being emptied.
	logic adv;

	cell_ctl_t                   ctl_c   [DIM+1];
	logic signed [WORD_BITS-1:0] value_c [DIM+1];
	logic signed [WORD_BITS-1:0] point_c [DIM+1][DIM];
	logic signed [ACC_BITS-1:0]  acc_c   [DIM+1][DIM];

	logic signed [FIELD_BITS-1:0] comp_in [POINT_COMPS];

	assign item.ready = adv;

	assign comp_in[0] = item.in_x;
	assign comp_in[1] = item.in_y;
	assign comp_in[2] = item.in_z;
	assign comp_in[3] = item.in_w;

	// Head of the chain: the request enters with empty row sums. Point
	// components are cut to the word width; those beyond the fourth are zero.
	always_comb begin
		ctl_c[0].valid = item.valid;
		ctl_c[0].kind  = item.kind;
		ctl_c[0].row   = item.row;
		ctl_c[0].col   = item.col;
		value_c[0]     = item.entry_value[WORD_BITS-1:0];
	end

	for (genvar j = 0; j < DIM; j++) begin : g_head
		if (j < POINT_COMPS) begin : g_comp
			assign point_c[0][j] = comp_in[j][WORD_BITS-1:0];
		end else begin : g_zero
			assign point_c[0][j] = '0;
		end
		assign acc_c[0][j] = '0;
	end

	// One cell for each matrix column; cell j adds column j times
	// component j onto every row sum.
	for (genvar j = 0; j < DIM; j++) begin : g_cell
		hpt_cell #(
			.DIM       (DIM),
			.WORD_BITS (WORD_BITS),
			.ACC_BITS  (ACC_BITS),
			.COL       (j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctl_i   (ctl_c[j]),
			.value_i (value_c[j]),
			.point_i (point_c[j]),
			.acc_i   (acc_c[j]),
			.ctl_o   (ctl_c[j+1]),
			.value_o (value_c[j+1]),
			.point_o (point_c[j+1]),
			.acc_o   (acc_c[j+1])
		);
	end

	// Tail: scale, clip and register the result; loads are dropped here.
	hpt_sat #(
		.DIM       (DIM),
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.ACC_BITS  (ACC_BITS)
	) u_sat (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (ctl_c[DIM]),
		.acc_i  (acc_c[DIM]),
		.adv    (adv),
		.result (result)
	);

endmodule

[tb/homogeneous_point_transform_tb.sv]
// ----------------------------------------------------------------------------
// homogeneous_point_transform_tb: self-checking bench for the point transform
// Drives matrix entry loads and point transforms through the request channel.
// A shadow copy of the matrix predicts every transformed point, and each
// result taken from the block is compared, field by field, in request order.
// Both channels idle and stall at random, with back-to-back stretches too.
// ----------------------------------------------------------------------------
module homogeneous_point_transform_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hpt_pkg::*;

	// A request passes every cell register and then the output register before it comes out the far end.
	localparam int LATENCY     = 2 * DIM_DEF + 1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;

	// Handy Q16.16 values.
	localparam logic [FIELD_BITS-1:0] Q_MAX  = 32'h7FFF_FFFF;
	localparam logic [FIELD_BITS-1:0] Q_MIN  = 32'h8000_0000;
	localparam logic [FIELD_BITS-1:0] Q_ONE  = 32'h0001_0000;
	localparam logic [FIELD_BITS-1:0] Q_LSB  = 32'h0000_0001;
	localparam logic [FIELD_BITS-1:0] Q_NLSB = 32'hFFFF_FFFF;

	// Saturation bounds, held at the width of the exact accumulator.
	localparam logic signed [127:0] ACC_MAX = 128'sd2147483647;
	localparam logic signed [127:0] ACC_MIN = -128'sd2147483648;

	// One transformed point as it leaves the block.
	typedef struct packed {
		logic [FIELD_BITS-1:0] x;
		logic [FIELD_BITS-1:0] y;
		logic [FIELD_BITS-1:0] z;
		logic [FIELD_BITS-1:0] w;
		logic                  sat;
	} xform_result_t;

	logic clk = 1'b0;
	logic arst_n;

	hpt_in_if  item_if ();
	hpt_out_if result_if ();

	homogeneous_point_transform uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	// Shadow of the matrix held by the block, and the transformed points that
	// have been requested but not yet returned, oldest first.
	logic signed [FIELD_BITS-1:0] shadow_matrix [DIM_DEF][DIM_DEF];
	xform_result_t                awaited_points [$];

	int  fault_count = 0;
	int  cycle_count = 0;
	bit  sender_idles   = 1'b1;
	bit  receiver_idles = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// A generous ceiling on the run; a hang ends here as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("homogeneous_point_transform_tb: errors");
			$finish;
		end
	end

	// Multiplies the shadow matrix by a point. Each row sums its four exact
	// 64-bit products in a 128-bit accumulator so that nothing can wrap, then
	// shifts right arithmetically (truncation towards minus infinity) and
	// clips the value to 32 signed bits, noting whether any row was clipped.
	function automatic xform_result_t matrix_times_point(
		input logic [FIELD_BITS-1:0] px, py, pz, pw
	);
		logic signed [FIELD_BITS-1:0] pt   [DIM_DEF];
		logic        [FIELD_BITS-1:0] comp [DIM_DEF];
		logic signed [63:0]           prod;
		logic signed [127:0]          acc;
		logic signed [127:0]          scaled;
		xform_result_t                res;
		pt[0]   = px;
		pt[1]   = py;
		pt[2]   = pz;
		pt[3]   = pw;
		res.sat = 1'b0;
		for (int i = 0; i < DIM_DEF; i++) begin
			acc = '0;
			for (int j = 0; j < DIM_DEF; j++) begin
				prod = shadow_matrix[i][j] * pt[j];
				acc  = acc + prod;
			end
			scaled = acc >>> FRAC_BITS_DEF;
			if (scaled > ACC_MAX) begin
				comp[i] = Q_MAX;
				res.sat = 1'b1;
			end else if (scaled < ACC_MIN) begin
				comp[i] = Q_MIN;
				res.sat = 1'b1;
			end else begin
				comp[i] = scaled[FIELD_BITS-1:0];
			end
		end
		res.x = comp[0];
		res.y = comp[1];
		res.z = comp[2];
		res.w = comp[3];
		return res;
	endfunction

	// Watches both channels at every edge. An accepted load updates the shadow
	// matrix; an accepted transform queues its prediction. An accepted result
	// is then matched against the oldest prediction. Prediction goes first,
	// which is safe since no result can leave in the cycle its request enters.
	always @(posedge clk) begin
		xform_result_t want;
		xform_result_t got;
		bit            bad;
		if (!arst_n) begin
			for (int i = 0; i < DIM_DEF; i++)
				for (int j = 0; j < DIM_DEF; j++)
					shadow_matrix[i][j] = '0;
		end else begin
			if (item_if.valid && item_if.ready) begin
				if (item_if.kind == KIND_LOAD)
					shadow_matrix[item_if.row][item_if.col] = item_if.entry_value;
				else
					awaited_points.push_back(matrix_times_point(item_if.in_x, item_if.in_y,
						item_if.in_z, item_if.in_w));
			end
			if (result_if.valid && result_if.ready) begin
				got = '{x: result_if.out_x, y: result_if.out_y, z: result_if.out_z,
					w: result_if.out_w, sat: result_if.saturated};
				if (awaited_points.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("%0t: result with nothing awaited: x=%h y=%h z=%h w=%h sat=%b",
							$realtime, got.x, got.y, got.z, got.w, got.sat);
				end else begin
					want = awaited_points.pop_front();
					bad  = (got.x !== want.x) || (got.y !== want.y) || (got.z !== want.z) ||
						(got.w !== want.w) || (got.sat !== want.sat);
					if (bad) begin
						fault_count++;
						if (fault_count <= REPORT_MAX)
							$display("%0t: mismatch: expected x=%h y=%h z=%h w=%h sat=%b, got x=%h y=%h z=%h w=%h sat=%b",
								$realtime, want.x, want.y, want.z, want.w, want.sat,
								got.x, got.y, got.z, got.w, got.sat);
					end
				end
			end
		end
	end

	// Result side: before each result it holds ready low for a drawn number of
	// cycles, then keeps it high until a result has been taken.
	initial begin
		int stall;
		result_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			stall = receiver_idles ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				result_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!result_if.valid);
		end
	end

	// Sends one request. It is called at a clock edge and returns at the edge
	// where the request was taken, so that the next one may follow at once.
	task automatic send_request(
		input logic                  kind,
		input logic [IDX_BITS-1:0]   row,
		input logic [IDX_BITS-1:0]   col,
		input logic [FIELD_BITS-1:0] entry_value,
		input logic [FIELD_BITS-1:0] px, py, pz, pw
	);
		int gap;
		gap = sender_idles ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid       <= 1'b1;
		item_if.kind        <= kind;
		item_if.row         <= row;
		item_if.col         <= col;
		item_if.entry_value <= entry_value;
		item_if.in_x        <= px;
		item_if.in_y        <= py;
		item_if.in_z        <= pz;
		item_if.in_w        <= pw;
		do
			@(posedge clk);
		while (!item_if.ready);
	endtask

	// A load carries random point fields, which the block must ignore.
	task automatic load_entry(
		input logic [IDX_BITS-1:0] row, col, input logic [FIELD_BITS-1:0] value
	);
		send_request(KIND_LOAD, row, col, value, $urandom(), $urandom(), $urandom(),
			$urandom());
	endtask

	// A transform carries random entry fields, which the block must ignore.
	task automatic transform_point(input logic [FIELD_BITS-1:0] px, py, pz, pw);
		send_request(KIND_XFORM, IDX_BITS'($urandom()), IDX_BITS'($urandom()), $urandom(),
			px, py, pz, pw);
	endtask

	// Mostly values of a few units either way, so that most results stay in
	// range, with the extremes, zero and full-width noise mixed in.
	function automatic logic [FIELD_BITS-1:0] draw_q16();
		case ($urandom_range(0, 11))
			0:       return Q_MAX;
			1:       return Q_MIN;
			2:       return '0;
			3, 4:    return $urandom();
			5:       return Q_ONE;
			default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
		endcase
	endfunction

	// Straight after reset the matrix is all zero, so even an extreme point
	// must come back as the origin.
	task automatic test_cleared_matrix();
		transform_point(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
	endtask

	// The identity matrix passes points through unchanged, the extremes too.
	task automatic test_identity();
		for (int i = 0; i < DIM_DEF; i++)
			load_entry(IDX_BITS'(i), IDX_BITS'(i), Q_ONE);
		transform_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		transform_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
	endtask

	// Huge entries against a huge component clip one row high and another
	// low, and then the other way round.
	task automatic test_saturation();
		load_entry(IDX_BITS'(0), IDX_BITS'(1), Q_MAX);
		load_entry(IDX_BITS'(1), IDX_BITS'(1), Q_MIN);
		transform_point('0, Q_MAX, '0, '0);
		transform_point('0, Q_MIN, '0, '0);
	endtask

	// A row of the most negative entries: against the most negative point the
	// sum needs more than 64 bits, and against an alternating point the huge
	// products cancel down to exactly one.
	task automatic test_wide_accumulation();
		for (int j = 0; j < DIM_DEF; j++)
			load_entry(IDX_BITS'(3), IDX_BITS'(j), Q_MIN);
		transform_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		transform_point(Q_MIN, Q_MAX, Q_MIN, Q_MAX);
	endtask

	// A product of minus one least significant bit must truncate towards
	// minus infinity, while plus one must vanish.
	task automatic test_truncation();
		load_entry(IDX_BITS'(2), IDX_BITS'(2), Q_LSB);
		transform_point('0, '0, Q_NLSB, '0);
		transform_point('0, '0, Q_LSB, '0);
	endtask

	// Random mix of loads and transforms under a given idling pattern.
	task automatic test_random_traffic(input int count, input bit src_idle, snk_idle);
		sender_idles   = src_idle;
		receiver_idles = snk_idle;
		repeat (count) begin
			if ($urandom_range(0, 99) < 35)
				load_entry(IDX_BITS'($urandom()), IDX_BITS'($urandom()), draw_q16());
			else
				transform_point(draw_q16(), draw_q16(), draw_q16(), draw_q16());
		end
	endtask

	// Lets everything drain, allows the last request's full latency for any
	// stray result to show itself, and gives the verdict.
	task automatic finish_run();
		item_if.valid <= 1'b0;
		while (awaited_points.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (fault_count == 0)
			$display("homogeneous_point_transform_tb: clean");
		else
			$display("homogeneous_point_transform_tb: errors");
		$finish;
	endtask

	initial begin
		arst_n              <= 1'b0;
		item_if.valid       <= 1'b0;
		item_if.kind        <= KIND_LOAD;
		item_if.row         <= '0;
		item_if.col         <= '0;
		item_if.entry_value <= '0;
		item_if.in_x        <= '0;
		item_if.in_y        <= '0;
		item_if.in_z        <= '0;
		item_if.in_w        <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_cleared_matrix();
		test_identity();
		test_saturation();
		test_wide_accumulation();
		test_truncation();

		// Random traffic: both sides idling, then flat out, then each side
		// idling on its own.
		test_random_traffic(300, 1'b1, 1'b1);
		test_random_traffic(150, 1'b0, 1'b0);
		test_random_traffic(150, 1'b1, 1'b0);
		test_random_traffic(200, 1'b0, 1'b1);

		finish_run();
	end

endmodule

[homogeneous_point_transform.f]
hdl/hpt_pkg.sv
hdl/hpt_in_if.sv
hdl/hpt_out_if.sv
hdl/hpt_cell.sv
hdl/hpt_sat.sv
hdl/homogeneous_point_transform.sv
tb/homogeneous_point_transform_tb.sv
